/* hw/rtl/ptro_pkg.sv */
// Shared types and constants for the point-to-rectangle offset block.
package ptro_pkg;

    localparam int unsigned CoordBitsDef = 20;
    localparam int unsigned CfgIdxBits   = 3;
    localparam int unsigned RecipBits    = 32;
    localparam int unsigned TFrac        = 16;
    localparam logic [TFrac:0] TOne      = {1'b1, {TFrac{1'b0}}};

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_ORIGIN  = 3'd0,
        CFG_SIDE_A  = 3'd1,
        CFG_SIDE_B  = 3'd2,
        CFG_NORMAL  = 3'd3,
        CFG_RECIP_A = 3'd4,
        CFG_RECIP_B = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ZONE_BELOW  = 2'd0,
        ZONE_WITHIN = 2'd1,
        ZONE_BEYOND = 2'd2
    } t_zone;

    typedef struct packed {
        logic mul;
        logic sum;
    } t_dot_en;

endpackage

/* hw/rtl/point_to_rectangle_offset.sv */
// Top level: offset from the nearest point of a configured rectangle to a query point.
// One transaction is accepted per cycle unless a full pipeline waits on the output; the seven
// valid-tagged stages each hold on their own, so empty stages keep filling while a result
// waits on the output. The multipliers of the dot products, the edge parameter and the face
// projection set the stage count. Reset clears all stage valid bits and all configuration
// registers to zero.
module point_to_rectangle_offset import ptro_pkg::*; #(
    parameter int unsigned COORD_BITS = CoordBitsDef
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [CfgIdxBits-1:0]                      i_cfg_idx,
    input  logic [3*COORD_BITS-1:0]                    i_cfg_data,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // Fields from bit 0: point_x, point_y, point_z, zero fill.
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]          s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // Fields from bit 0: offset_x, offset_y, offset_z, region_code, zero fill.
    output logic [((3*COORD_BITS+4+7)/8)*8-1:0]        m_axis_tdata
);

    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned NF    = CB - 3;
    localparam int unsigned NS    = 7;
    localparam int unsigned OUT_W = ((3*CB+4+7)/8)*8;
    localparam int unsigned RW    = 2*CB + 3;
    localparam int unsigned LW    = 2*CB + 2;
    localparam int unsigned UW    = 2*CB;
    localparam int unsigned PW    = UW + 16;
    localparam int unsigned DW    = CB + 6;
    localparam int unsigned NDW   = 2*CB + 6;
    localparam int unsigned EW    = CB + 18;
    localparam int unsigned QW    = CB + 4;
    localparam int unsigned FW    = CB + 9;
    localparam logic signed [FW-1:0] SatHi = FW'((2 ** (CB-1)) - 1);
    localparam logic signed [FW-1:0] SatLo = FW'(-(2 ** (CB-1)));

    logic [3*CB-1:0]        r_origin, r_side_a, r_side_b, r_normal;
    logic [RecipBits-1:0]   r_rla, r_rlb;
    logic [NS:1]            r_vld;
    logic [NS:1]            w_en;

    logic signed [CB-1:0]   w_o [3], w_a [3], w_b [3], w_n [3], w_pin [3];
    logic signed [CB:0]     r1_rel [3];
    logic signed [CB-1:0]   r1_p [3], r2_p [3], r3_p [3], r4_p [3], r5_p [3], r6_p [3];
    logic signed [RW-1:0]   w_ra, w_rb, w_rn;
    logic signed [LW-1:0]   w_la, w_lb;
    t_zone                  r4_za, r4_zb, r5_za, r5_zb, r6_za, r6_zb;
    logic signed [DW-1:0]   r4_d;
    logic [PW-1:0]          r4_pha, r4_pla, r4_phb, r4_plb;
    logic [PW:0]            w_ta_sum, w_tb_sum;
    logic [TFrac:0]         r5_ta, r5_tb;
    logic signed [NDW-1:0]  r5_nd [3];
    logic signed [EW-1:0]   r6_ea [3], r6_eb [3];
    logic signed [FW-1:0]   r6_face [3];
    logic signed [CB-1:0]   r7_off [3];
    logic [3:0]             r7_region;

    function automatic t_zone zone_of(input logic signed [RW-1:0] r,
                                      input logic signed [LW-1:0] len);
        if (r < 0) begin
            zone_of = ZONE_BELOW;
        end else if (r > RW'(len)) begin
            zone_of = ZONE_BEYOND;
        end else begin
            zone_of = ZONE_WITHIN;
        end
    endfunction

    function automatic logic [TFrac:0] edge_param(input t_zone z, input logic [PW:0] sum);
        logic [TFrac:0] t;
        t = (sum > (PW+1)'(TOne)) ? TOne : sum[TFrac:0];
        unique case (z)
            ZONE_BELOW:  edge_param = '0;
            ZONE_WITHIN: edge_param = t;
            ZONE_BEYOND: edge_param = TOne;
            default:     edge_param = '0;
        endcase
    endfunction

    function automatic logic signed [CB-1:0] sat_coord(input logic signed [FW-1:0] x);
        if (x > SatHi) begin
            sat_coord = SatHi[CB-1:0];
        end else if (x < SatLo) begin
            sat_coord = SatLo[CB-1:0];
        end else begin
            sat_coord = x[CB-1:0];
        end
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_o[i]   = r_origin[CB*i +: CB];
            w_a[i]   = r_side_a[CB*i +: CB];
            w_b[i]   = r_side_b[CB*i +: CB];
            w_n[i]   = r_normal[CB*i +: CB];
            w_pin[i] = s_axis_tdata[CB*i +: CB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_side_a <= '0;
            r_side_b <= '0;
            r_normal <= '0;
            r_rla    <= '0;
            r_rlb    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN:  r_origin <= i_cfg_data;
                CFG_SIDE_A:  r_side_a <= i_cfg_data;
                CFG_SIDE_B:  r_side_b <= i_cfg_data;
                CFG_NORMAL:  r_normal <= i_cfg_data;
                CFG_RECIP_A: r_rla    <= i_cfg_data[RecipBits-1:0];
                CFG_RECIP_B: r_rlb    <= i_cfg_data[RecipBits-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_en[NS] = !r_vld[NS] || m_axis_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_en[1];
    assign m_axis_tvalid = r_vld[NS];

    ptro_dot3 #(.WA(CB + 1), .WB(CB)) u_dot_ra (
        .i_clk (i_clk),
        .i_en  ('{mul: w_en[2], sum: w_en[3]}),
        .i_a   (r1_rel),
        .i_b   (w_a),
        .o_sum (w_ra)
    );

    ptro_dot3 #(.WA(CB + 1), .WB(CB)) u_dot_rb (
        .i_clk (i_clk),
        .i_en  ('{mul: w_en[2], sum: w_en[3]}),
        .i_a   (r1_rel),
        .i_b   (w_b),
        .o_sum (w_rb)
    );

    ptro_dot3 #(.WA(CB + 1), .WB(CB)) u_dot_rn (
        .i_clk (i_clk),
        .i_en  ('{mul: w_en[2], sum: w_en[3]}),
        .i_a   (r1_rel),
        .i_b   (w_n),
        .o_sum (w_rn)
    );

    ptro_dot3 #(.WA(CB), .WB(CB)) u_dot_la (
        .i_clk (i_clk),
        .i_en  ('{mul: 1'b1, sum: 1'b1}),
        .i_a   (w_a),
        .i_b   (w_a),
        .o_sum (w_la)
    );

    ptro_dot3 #(.WA(CB), .WB(CB)) u_dot_lb (
        .i_clk (i_clk),
        .i_en  ('{mul: 1'b1, sum: 1'b1}),
        .i_a   (w_b),
        .i_b   (w_b),
        .o_sum (w_lb)
    );

    assign w_ta_sum = (PW+1)'(r4_pha) + (PW+1)'(r4_pla >> TFrac);
    assign w_tb_sum = (PW+1)'(r4_phb) + (PW+1)'(r4_plb >> TFrac);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i]   <= w_pin[i];
                r1_rel[i] <= (CB+1)'(w_pin[i]) - (CB+1)'(w_o[i]);
            end
        end
        if (w_en[2]) begin
            r2_p <= r1_p;
        end
        if (w_en[3]) begin
            r3_p <= r2_p;
        end
        if (w_en[4]) begin
            r4_p   <= r3_p;
            r4_za  <= zone_of(w_ra, w_la);
            r4_zb  <= zone_of(w_rb, w_lb);
            r4_d   <= DW'(w_rn >>> NF);
            r4_pha <= PW'(w_ra[UW-1:0]) * PW'(r_rla[31:16]);
            r4_pla <= PW'(w_ra[UW-1:0]) * PW'(r_rla[15:0]);
            r4_phb <= PW'(w_rb[UW-1:0]) * PW'(r_rlb[31:16]);
            r4_plb <= PW'(w_rb[UW-1:0]) * PW'(r_rlb[15:0]);
        end
        if (w_en[5]) begin
            r5_p  <= r4_p;
            r5_za <= r4_za;
            r5_zb <= r4_zb;
            r5_ta <= edge_param(r4_za, w_ta_sum);
            r5_tb <= edge_param(r4_zb, w_tb_sum);
            for (int i = 0; i < 3; i++) begin
                r5_nd[i] <= NDW'(w_n[i]) * NDW'(r4_d);
            end
        end
        if (w_en[6]) begin
            r6_p  <= r5_p;
            r6_za <= r5_za;
            r6_zb <= r5_zb;
            for (int i = 0; i < 3; i++) begin
                r6_ea[i]   <= EW'(w_a[i]) * EW'($signed({1'b0, r5_ta}));
                r6_eb[i]   <= EW'(w_b[i]) * EW'($signed({1'b0, r5_tb}));
                r6_face[i] <= FW'(r5_nd[i] >>> NF);
            end
        end
        if (w_en[7]) begin
            for (int i = 0; i < 3; i++) begin
                r7_off[i] <= sat_coord(
                    (r6_za == ZONE_WITHIN && r6_zb == ZONE_WITHIN) ? r6_face[i] :
                    FW'((QW+1)'(r6_p[i]) - (QW+1)'(QW'(w_o[i]) + QW'(r6_ea[i] >>> TFrac)
                                                 + QW'(r6_eb[i] >>> TFrac))));
            end
            r7_region <= 4'(r6_zb) * 4'd3 + 4'(r6_za);
        end
    end

    assign m_axis_tdata = OUT_W'({r7_region, r7_off[2], r7_off[1], r7_off[0]});

endmodule

/* hw/rtl/ptro_dot3.sv */
// Two-stage pipelined signed dot product of two 3-vectors.
module ptro_dot3 import ptro_pkg::*; #(
    parameter int unsigned WA = CoordBitsDef + 1,
    parameter int unsigned WB = CoordBitsDef
) (
    input  logic                     i_clk,
    input  t_dot_en                  i_en,
    input  logic signed [WA-1:0]     i_a [3],
    input  logic signed [WB-1:0]     i_b [3],
    output logic signed [WA+WB+1:0]  o_sum
);

    localparam int unsigned PW = WA + WB;

    logic signed [PW-1:0]   r_prod [3];
    logic signed [PW+1:0]   r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= PW'(i_a[i]) * PW'(i_b[i]);
            end
        end
        if (i_en.sum) begin
            r_sum <= (PW+2)'(r_prod[0]) + (PW+2)'(r_prod[1]) + (PW+2)'(r_prod[2]);
        end
    end

    assign o_sum = r_sum;

endmodule

/* verif/tb_top.sv */
// Testbench that streams query points with random idling and checks every offset.
`timescale 1ns / 1ps

module tb_top import ptro_pkg::*; ();

    localparam int unsigned Cb         = CoordBitsDef;
    localparam int unsigned NormFrac   = CoordBitsDef - 3;
    localparam int unsigned InBits     = ((3 * Cb + 7) / 8) * 8;
    localparam int unsigned OutBits    = ((3 * Cb + 4 + 7) / 8) * 8;
    localparam longint      CoordMax   = (64'sd1 <<< (Cb - 1)) - 64'sd1;
    localparam longint      CoordMin   = -CoordMax - 64'sd1;
    localparam int unsigned Latency    = 7;
    localparam int unsigned CycleLimit = 200000;

    typedef enum int {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_PERIODIC,
        RDY_SPARSE
    } t_ready_pattern;

    typedef struct packed {
        logic [3:0]         region;
        logic [2:0][Cb-1:0] off;
    } t_offset_result;

    class offset_scoreboard;
        logic [3*Cb-1:0]      origin, side_a, side_b, normal;
        logic [RecipBits-1:0] recip_a, recip_b;
        t_offset_result       expected_offsets [$];
        int                   errors;

        function new();
            origin  = '0;
            side_a  = '0;
            side_b  = '0;
            normal  = '0;
            recip_a = '0;
            recip_b = '0;
            errors  = 0;
        endfunction

        static function logic [Cb-1:0] clamp_coord(longint v);
            longint c;
            c = (v > CoordMax) ? CoordMax : ((v < CoordMin) ? CoordMin : v);
            return c[Cb-1:0];
        endfunction

        static function longint coord(logic [3*Cb-1:0] vec, int k);
            return longint'($signed(vec[k*Cb +: Cb]));
        endfunction

        static function longint dot3(input longint x[3], input longint y[3]);
            return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
        endfunction

        static function t_zone zone_of(longint r, longint len);
            if (r < 0) return ZONE_BELOW;
            if (r > len) return ZONE_BEYOND;
            return ZONE_WITHIN;
        endfunction

        // Fraction along a side in Q1.16, from the projection and the stored reciprocal.
        static function longint edge_fraction(longint r, logic [RecipBits-1:0] recip);
            longint unsigned ur, t;
            ur = r;
            t  = ur * recip[31:16] + ((ur * recip[15:0]) >> TFrac);
            if (t > TOne) t = TOne;
            return longint'(t);
        endfunction

        function void set_reg(t_cfg_idx idx, logic [3*Cb-1:0] val);
            case (idx)
                CFG_ORIGIN:  origin  = val;
                CFG_SIDE_A:  side_a  = val;
                CFG_SIDE_B:  side_b  = val;
                CFG_NORMAL:  normal  = val;
                CFG_RECIP_A: recip_a = val[RecipBits-1:0];
                CFG_RECIP_B: recip_b = val[RecipBits-1:0];
                default: ;
            endcase
        endfunction

        function t_offset_result nearest_offset(logic [3*Cb-1:0] pt);
            longint p[3], o[3], a[3], b[3], n[3], rel[3], q[3], off[3];
            longint ra, rb, la, lb, ta, tb, d;
            t_zone za, zb;
            t_offset_result res;
            for (int i = 0; i < 3; i++) begin
                p[i]   = coord(pt, i);
                o[i]   = coord(origin, i);
                a[i]   = coord(side_a, i);
                b[i]   = coord(side_b, i);
                n[i]   = coord(normal, i);
                rel[i] = p[i] - o[i];
            end
            ra = dot3(rel, a);
            rb = dot3(rel, b);
            la = dot3(a, a);
            lb = dot3(b, b);
            za = zone_of(ra, la);
            zb = zone_of(rb, lb);
            if (za == ZONE_WITHIN && zb == ZONE_WITHIN) begin
                // Over the face: project the relative point onto the normal.
                d = dot3(rel, n) >>> NormFrac;
                for (int i = 0; i < 3; i++) off[i] = (n[i] * d) >>> NormFrac;
            end else begin
                ta = (za == ZONE_WITHIN) ? edge_fraction(ra, recip_a) : 64'sd0;
                tb = (zb == ZONE_WITHIN) ? edge_fraction(rb, recip_b) : 64'sd0;
                for (int i = 0; i < 3; i++) begin
                    q[i] = o[i];
                    if (za == ZONE_BEYOND) q[i] += a[i];
                    else if (za == ZONE_WITHIN) q[i] += (a[i] * ta) >>> TFrac;
                    if (zb == ZONE_BEYOND) q[i] += b[i];
                    else if (zb == ZONE_WITHIN) q[i] += (b[i] * tb) >>> TFrac;
                    off[i] = p[i] - q[i];
                end
            end
            for (int i = 0; i < 3; i++) res.off[i] = clamp_coord(off[i]);
            res.region = 4'(3 * int'(zb) + int'(za));
            return res;
        endfunction

        function void note_point(logic [3*Cb-1:0] pt);
            expected_offsets.push_back(nearest_offset(pt));
        endfunction

        function void check_offset(logic [OutBits-1:0] data);
            t_offset_result got, want;
            got = data[3*Cb+3:0];
            if (expected_offsets.size() == 0) begin
                $display("%0t: result transaction with none expected, actual %h", $time, data);
                errors++;
                return;
            end
            want = expected_offsets.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.off[i] !== want.off[i]) begin
                    $display("%0t: offset[%0d] mismatch, expected %0d, actual %0d", $time, i,
                             $signed(want.off[i]), $signed(got.off[i]));
                    errors++;
                end
            end
            if (got.region !== want.region) begin
                $display("%0t: region_code mismatch, expected %0d, actual %0d", $time,
                         want.region, got.region);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CfgIdxBits-1:0] i_cfg_idx     = '0;
    logic [3*Cb-1:0]       i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [InBits-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OutBits-1:0]    m_axis_tdata;

    offset_scoreboard      sb            = new();
    logic [3*Cb-1:0]       point_queue [$];
    t_ready_pattern        ready_mode    = RDY_ALWAYS;
    int unsigned           cycle_count   = 0;

    point_to_rectangle_offset u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        case (ready_mode)
            RDY_ALWAYS:   m_axis_tready <= 1'b1;
            RDY_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            RDY_PERIODIC: m_axis_tready <= ((cycle_count % 7) >= 3);
            default:      m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_point(s_axis_tdata[3*Cb-1:0]);
            if (m_axis_tvalid && m_axis_tready) sb.check_offset(m_axis_tdata);
        end
    end

    function automatic logic [3*Cb-1:0] vec3(longint x, longint y, longint z);
        return {offset_scoreboard::clamp_coord(z), offset_scoreboard::clamp_coord(y),
                offset_scoreboard::clamp_coord(x)};
    endfunction

    function automatic logic [3*Cb-1:0] rand60();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[3*Cb-1:0];
    endfunction

    function automatic logic [RecipBits-1:0] recip_of(longint len_sq);
        longint q;
        if (len_sq <= 0) return '1;
        q = (64'sd1 <<< 32) / len_sq;
        return (q > 64'sd4294967295) ? '1 : q[RecipBits-1:0];
    endfunction

    // Point at fractions fa, fb (signed Q47.16) along the sides, lifted by h along the normal.
    function automatic logic [3*Cb-1:0] point_at(longint fa, longint fb, longint h);
        logic [3*Cb-1:0] pt;
        longint          c;
        for (int i = 0; i < 3; i++) begin
            c = offset_scoreboard::coord(sb.origin, i)
                + ((offset_scoreboard::coord(sb.side_a, i) * fa) >>> TFrac)
                + ((offset_scoreboard::coord(sb.side_b, i) * fb) >>> TFrac)
                + ((offset_scoreboard::coord(sb.normal, i) * h) >>> NormFrac);
            pt[i*Cb +: Cb] = offset_scoreboard::clamp_coord(c);
        end
        return pt;
    endfunction

    function automatic void add_random(int count);
        longint fa, fb;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                point_queue.push_back(rand60());
            end else begin
                fa = longint'($urandom_range(0, 131072)) - 32768;
                fb = longint'($urandom_range(0, 131072)) - 32768;
                case ($urandom_range(0, 7))
                    0: fa = 0;
                    1: fa = 65536;
                    2: fb = 0;
                    3: fb = 65536;
                    default: ;
                endcase
                point_queue.push_back(point_at(fa, fb, longint'($urandom_range(0, 8000)) - 4000));
            end
        end
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [3*Cb-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_rectangle(input logic [3*Cb-1:0] org, side_a, side_b, nrm, rcp_a,
                                  rcp_b);
        write_reg(CFG_ORIGIN, org);
        write_reg(CFG_SIDE_A, side_a);
        write_reg(CFG_SIDE_B, side_b);
        write_reg(CFG_NORMAL, nrm);
        write_reg(CFG_RECIP_A, rcp_a);
        write_reg(CFG_RECIP_B, rcp_b);
        i_cfg_we <= 1'b0;
    endtask

    // Side A = (u, v, w), side B = s * (-v, u, 0), normal along A x B.
    task automatic load_tilted(input logic [3*Cb-1:0] org, input longint u, v, w, s);
        longint cx, cy, cz;
        real    mag;
        cx  = -w * u * s;
        cy  = -w * v * s;
        cz  = (u * u + v * v) * s;
        mag = $sqrt(real'(cx) * real'(cx) + real'(cy) * real'(cy) + real'(cz) * real'(cz));
        load_rectangle(org, vec3(u, v, w), vec3(-v * s, u * s, 0),
                       vec3(longint'(real'(cx) / mag * 131072.0),
                            longint'(real'(cy) / mag * 131072.0),
                            longint'(real'(cz) / mag * 131072.0)),
                       (3*Cb)'(recip_of(u * u + v * v + w * w)),
                       (3*Cb)'(recip_of((u * u + v * v) * s * s)));
    endtask

    task automatic run_phase(input int gap_max, input t_ready_pattern rdy);
        int burst_left;
        int gap;
        burst_left = 0;
        ready_mode = rdy;
        while (point_queue.size() != 0) begin
            if (burst_left == 0) begin
                gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                burst_left = $urandom_range(1, 20);
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= InBits'(point_queue.pop_front());
            burst_left--;
            do @(posedge i_clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
        while (sb.expected_offsets.size() != 0) @(posedge i_clk);
        repeat (Latency + 3) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers still at reset: every side is degenerate.
        point_queue.push_back(vec3(0, 0, 0));
        point_queue.push_back(vec3(CoordMax, CoordMax, CoordMax));
        point_queue.push_back(vec3(CoordMin, CoordMin, CoordMin));
        point_queue.push_back(vec3(CoordMin, CoordMax, CoordMin));
        point_queue.push_back({3{20'h55555}});
        add_random(60);
        run_phase(3, RDY_MOSTLY);

        // Axis-aligned rectangle: all nine regions and the corners exactly.
        load_tilted(vec3(-1000, 500, 200), 4096, 0, 0, 1);
        for (int zb = 0; zb < 3; zb++) begin
            for (int za = 0; za < 3; za++) begin
                point_queue.push_back(point_at(-16384 + 49152 * za, -16384 + 49152 * zb, 500));
            end
        end
        point_queue.push_back(point_at(0, 0, 0));
        point_queue.push_back(point_at(65536, 0, 0));
        point_queue.push_back(point_at(0, 65536, 0));
        point_queue.push_back(point_at(65536, 65536, 0));
        add_random(200);
        run_phase(4, RDY_PERIODIC);

        load_tilted(vec3(longint'($urandom_range(0, 200000)) - 100000,
                         longint'($urandom_range(0, 200000)) - 100000,
                         longint'($urandom_range(0, 200000)) - 100000),
                    longint'($urandom_range(1, 3000)), longint'($urandom_range(0, 6000)) - 3000,
                    longint'($urandom_range(0, 4000)) - 2000, longint'($urandom_range(1, 2)));
        add_random(250);
        run_phase(2, RDY_SPARSE);

        // Extreme registers: saturation, full and zero reciprocals.
        load_rectangle(vec3(CoordMin, CoordMin, CoordMin), vec3(CoordMax, CoordMax, CoordMax),
                       vec3(CoordMax, CoordMax, CoordMax), vec3(CoordMax, CoordMax, CoordMax),
                       (3*Cb)'(32'hFFFF_FFFF), '0);
        point_queue.push_back(vec3(CoordMax, CoordMax, CoordMax));
        point_queue.push_back(vec3(CoordMin, CoordMin, CoordMin));
        point_queue.push_back(vec3(CoordMin, CoordMax, CoordMin));
        point_queue.push_back(vec3(0, 0, 0));
        add_random(120);
        run_phase(3, RDY_MOSTLY);

        load_rectangle(vec3(CoordMax, CoordMax, CoordMax), vec3(CoordMin, CoordMin, CoordMin),
                       vec3(CoordMin, CoordMax, 0), vec3(CoordMin, CoordMin, CoordMin),
                       '0, (3*Cb)'(32'hFFFF_FFFF));
        add_random(120);
        run_phase(5, RDY_PERIODIC);

        // Unconstrained register contents, upper bits of the reciprocal writes included.
        load_rectangle(rand60(), rand60(), rand60(), rand60(), rand60(), rand60());
        add_random(150);
        run_phase(3, RDY_SPARSE);

        // Short sides streamed back to back with no stalls.
        load_tilted(vec3(longint'($urandom_range(0, 4000)) - 2000,
                         longint'($urandom_range(0, 4000)) - 2000,
                         longint'($urandom_range(0, 4000)) - 2000),
                    longint'($urandom_range(0, 128)) - 64, longint'($urandom_range(1, 64)),
                    longint'($urandom_range(0, 64)) - 32, 1);
        add_random(250);
        run_phase(0, RDY_ALWAYS);

        if (sb.errors == 0 && sb.expected_offsets.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
